/* rtl/itdt_pkg.sv */
`timescale 1ns / 1ps

package itdt_pkg;

   // Width of the value port and the number of its bits that are converted
   localparam int IN_W       = 32;
   localparam int VALUE_BITS = 32;

   // Magnitude register width: the most negative value needs all VALUE_BITS bits
   localparam int MAG_W      = VALUE_BITS;

   // Decimal digits of 2^VALUE_BITS - 1, rounded up (log10(2) ~ 0.30103)
   localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

   localparam int TEXT_W     = 8;

   localparam logic [TEXT_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [TEXT_W-1:0] CHAR_MINUS   = 8'd45;
   localparam logic [TEXT_W-1:0] CHAR_NEWLINE = 8'd10;

   typedef logic [BCD_DIGITS-1:0][3:0] digits_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // capture the input value
      logic shift;         // one double-dabble step
      logic locate;        // find the leading nonzero digit
      logic emit_sign;
      logic emit_digit;
      logic emit_newline;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic negative;
      logic last_digit;
      logic newline;
      logic out_free;
   } status_type;

endpackage

/* rtl/itdt_ctrl.sv */
`timescale 1ns / 1ps

module itdt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  itdt_pkg::status_type  status,
   output itdt_pkg::cmd_type     cmd
);
   import itdt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONVERT,
      S_LOCATE,
      S_SIGN,
      S_DIGIT,
      S_NEWLINE
   } state_type;

   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_BITS - 1);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = S_CONVERT;
            end
         end
         S_CONVERT: begin
            cmd.shift  = 1'b1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = S_LOCATE;
            end
         end
         S_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = status.negative ? S_SIGN : S_DIGIT;
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = status.newline ? S_NEWLINE : S_IDLE;
               end
            end
         end
         S_NEWLINE: begin
            if (status.out_free) begin
               cmd.emit_newline = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   a_accept_starts_convert: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CONVERT))
      else $error("accepted transaction did not start conversion");

   a_locate_after_full_convert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOCATE) |->
         ($past(state_ff) == S_CONVERT && $past(bit_cnt_ff) == BIT_LAST))
      else $error("digit search before all bits shifted");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_sign, cmd.emit_digit, cmd.emit_newline}))
      else $error("more than one byte emitted in a cycle");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit || cmd.emit_newline) |-> status.out_free)
      else $error("byte emitted over a waiting transaction");

endmodule

/* rtl/itdt_dp.sv */
`timescale 1ns / 1ps

module itdt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [itdt_pkg::IN_W-1:0]     req_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [itdt_pkg::TEXT_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   input  itdt_pkg::cmd_type             cmd,
   output itdt_pkg::status_type          status
);
   import itdt_pkg::*;

   logic [MAG_W-1:0]      raw;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   digits_type            bcd_ff, bcd_in, adj;
   logic [BCD_W-1:0]      adj_flat;
   logic [DIG_IDX_W-1:0]  idx_ff, idx_in, top;
   logic                  newline_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [TEXT_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   assign raw = req_tdata[MAG_W-1:0];

   // Add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end
   assign adj_flat = adj;

   always_comb begin
      top = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            top = DIG_IDX_W'(i);
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      bcd_in = bcd_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         neg_in = raw[MAG_W-1];
         mag_in = raw[MAG_W-1] ? (~raw) + MAG_W'(1) : raw;
         bcd_in = '0;
      end else if (cmd.shift) begin
         bcd_in = {adj_flat[BCD_W-2:0], mag_ff[MAG_W-1]};
         mag_in = {mag_ff[MAG_W-2:0], 1'b0};
      end else if (cmd.locate) begin
         idx_in = top;
      end else if (cmd.emit_digit) begin
         idx_in = idx_ff - DIG_IDX_W'(1);
      end
   end

   // Output register: hold until taken, reload when a byte is emitted
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (cmd.emit_sign) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = CHAR_MINUS;
         rsp_tlast_in  = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = CHAR_ZERO + {4'd0, bcd_ff[idx_ff]};
         rsp_tlast_in  = (idx_ff == '0) && !newline_ff;
      end else if (cmd.emit_newline) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = CHAR_NEWLINE;
         rsp_tlast_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         newline_ff    <= 1'b1;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            newline_ff <= csr_data;
         end
      end
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      bcd_ff       <= bcd_in;
      idx_ff       <= idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);
   assign status.newline    = newline_ff;
   assign status.out_free   = ~rsp_tvalid_ff | rsp_tready;

   a_digit_is_decimal: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (bcd_ff[idx_ff] <= 4'd9))
      else $error("non-decimal digit emitted");

   a_last_digit_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |=> (rsp_tlast_ff == ($past(idx_ff) == '0 && !newline_ff)))
      else $error("last flag wrong on digit byte");

   a_newline_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_newline |=> (rsp_tlast_ff && rsp_tdata_ff == CHAR_NEWLINE))
      else $error("newline byte not flagged last");

endmodule

/* rtl/integer_to_decimal_text.sv */
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// req channel: one transaction carries a 32-bit two's complement value.
// rsp channel: the text leaves one byte per transaction: '-' for a negative
//   value, then the digits most significant first without leading zeros,
//   then '\n' if append_newline is set; tlast marks the final byte.
// csr channel: writes append_newline (csr_data bit); always ready. Write it
//   only while no conversion is in flight. Reset value is 1.
// Timing: the value is converted by a double-dabble unit, one input bit per
//   cycle, then the leading digit is found. The first byte is then loaded into
//   the output register; bytes then follow one per cycle while the receiver
//   does not stall. A value's text is 1 to 12 bytes long.
//   req_tready is high only while no value is being converted or emitted.
// A stall on rsp holds the current byte in the output register and pauses
//   the byte sequence; the next value can be accepted while the final byte
//   still waits.
// Reset (synchronous, active high) drops any value in progress, clears the
//   output valid and sets append_newline back to 1.
module integer_to_decimal_text (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [itdt_pkg::IN_W-1:0]     req_tdata,   // [31:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [itdt_pkg::TEXT_W-1:0]   rsp_tdata,   // [7:0] text_byte
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);
   import itdt_pkg::*;

   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   itdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   itdt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* sim/tb_integer_to_decimal_text.sv */
`timescale 1ns / 1ps

module tb_integer_to_decimal_text;
   import itdt_pkg::*;

   localparam int DEC_BASE         = 10;
   localparam int TIMEOUT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES    = 50;
   localparam int LONG_HOLD_CYCLES = 600;

   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              last_byte;
   } text_char_t;

   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic [IN_W-1:0]   req_tdata  = '0;
   logic              rsp_tready = 1'b0;
   logic              csr_valid  = 1'b0;
   logic              csr_data   = 1'b0;
   logic              req_tready;
   logic              rsp_tvalid;
   logic [TEXT_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_ready;

   text_char_t  expected_text[$];
   bit          newline_on     = 1'b1;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          burst_left     = 0;
   bit          gaps_on        = 1'b1;
   bit          long_hold      = 1'b0;
   rx_pattern_t rx_mode        = RX_FREE;
   event        long_hold_ev;

   always #5 clock = ~clock;

   integer_to_decimal_text uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Expected text of one value: optional sign, digits MSD first, optional newline
   function automatic void predict_text(logic [IN_W-1:0] value);
      logic [IN_W-1:0] mag;
      logic [3:0]      digit_list [BCD_DIGITS];
      int              count;
      bit              negative;
      negative = value[IN_W-1];
      // two's complement negation also gives 2^31 for the most negative value
      mag = negative ? (~value + 1'b1) : value;
      count = 0;
      do begin
         digit_list[count] = 4'(mag % DEC_BASE);
         mag = mag / DEC_BASE;
         count++;
      end while (mag != 0);
      if (negative)
         expected_text.push_back(text_char_t'{CHAR_MINUS, 1'b0});
      for (int i = count - 1; i >= 0; i--)
         expected_text.push_back(text_char_t'{CHAR_ZERO + TEXT_W'(digit_list[i]),
                                              (i == 0) && !newline_on});
      if (newline_on)
         expected_text.push_back(text_char_t'{CHAR_NEWLINE, 1'b1});
   endfunction

   function automatic logic [IN_W-1:0] random_value();
      logic [IN_W-1:0] pow10;
      logic [IN_W-1:0] mag;
      logic [IN_W-1:0] result;
      int              digits;
      case ($urandom_range(0, 3))
         0: result = $urandom();
         1: begin
            // uniform over digit count
            digits = $urandom_range(1, 10);
            pow10  = 1;
            repeat (digits - 1) pow10 = pow10 * DEC_BASE;
            if (digits == 10)
               mag = $urandom_range(32'h7FFF_FFFF, pow10);
            else
               mag = $urandom_range(pow10 * DEC_BASE - 1, pow10 - 1);
            result = $urandom_range(0, 1) ? -mag : mag;
         end
         2: begin
            // just at or below a power of ten
            pow10 = 1;
            repeat ($urandom_range(0, 9)) pow10 = pow10 * DEC_BASE;
            mag    = pow10 - $urandom_range(0, 1);
            result = $urandom_range(0, 1) ? -mag : mag;
         end
         default: result = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 20)
                                               : 32'h7FFF_FFFF - $urandom_range(0, 20);
      endcase
      return result;
   endfunction

   task automatic send_value(input logic [IN_W-1:0] value);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_text(value);
   endtask

   task automatic wait_text_drained();
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_newline(input bit flag);
      wait_text_drained();
      csr_valid <= 1'b1;
      csr_data  <= flag;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      newline_on = flag;
   endtask

   // Reset default first (newline on), then the same kinds of values without newline
   task automatic test_directed_values();
      int with_newline [16] = '{0, 1, 9, 10, 99, 100, -1, -9, -10, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0001, 1000000000, 999999999,
                                -1000000000, 32'h5555_5555};
      int no_newline [8] = '{0, 7, -5, 42, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF,
                             12345678};
      rx_mode = RX_LIGHT;
      foreach (with_newline[i]) send_value(with_newline[i]);
      write_newline(1'b0);
      foreach (no_newline[i]) send_value(no_newline[i]);
   endtask

   task automatic test_random_values();
      for (int phase = 0; phase < 6; phase++) begin
         write_newline(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
         rx_mode = rx_pattern_t'(phase % 4);
         gaps_on = (phase != 2);
         repeat (30) send_value(random_value());
      end
   endtask

   // Hold the output off for a long stretch while values keep coming
   task automatic test_output_stall();
      write_newline(1'b1);
      rx_mode = RX_FREE;
      gaps_on = 1'b0;
      -> long_hold_ev;
      repeat (16) send_value(random_value());
      wait_text_drained();
   endtask

   always @(posedge clock) begin
      if (long_hold)
         rsp_tready <= 1'b0;
      else
         case (rx_mode)
            RX_FREE:  rsp_tready <= 1'b1;
            RX_LIGHT: rsp_tready <= ($urandom_range(0, 7) != 0);
            RX_HEAVY: rsp_tready <= 1'($urandom_range(0, 1));
            default:  rsp_tready <= (cycle_count % 7) >= 3;
         endcase
   end

   initial forever begin
      @(long_hold_ev);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin : check_text
      text_char_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_text.size() == 0) begin
            $error("text_byte: expected none, actual %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.text_byte) begin
               $error("text_byte: expected %h, actual %h", want.text_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_byte) begin
               $error("last_byte: expected %b, actual %b", want.last_byte, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("tb_integer_to_decimal_text NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_values();
      test_output_stall();
      wait_text_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_integer_to_decimal_text OK");
      else
         $display("tb_integer_to_decimal_text NOT OK");
      $finish;
   end

endmodule

/* files.f */
rtl/itdt_pkg.sv
rtl/itdt_ctrl.sv
rtl/itdt_dp.sv
rtl/integer_to_decimal_text.sv
sim/tb_integer_to_decimal_text.sv
